@@ hw/rtl/mds_pkg.sv @@
package mds_pkg;

  localparam int SCREEN_WIDTH  = 400;
  localparam int SCREEN_HEIGHT = 240;
  localparam int BUFFER_WIDTH  = 416;

  localparam int STRIDE      = (BUFFER_WIDTH + 7) / 8;
  localparam int STORE_DEPTH = STRIDE * SCREEN_HEIGHT;
  localparam int AW          = $clog2(STORE_DEPTH);

  // coordinates stay below 1024
  localparam int CW = 10;
  localparam int SW = CW + 2;
  localparam int LW = CW + 1;

  // floor(v / s) == (v * RECIP[s]) >> RK for v < 2**CW, 0 < s < 16; s = 0 acts as 1
  localparam int RK = 18;
  localparam int RW = RK + 1;
  localparam int PW = CW + RW;

  typedef logic [RW-1:0] mds_recip_t;
  typedef logic [LW-1:0] mds_lim_t;

  localparam mds_recip_t RECIP [16] = '{
    RW'(2**RK),             RW'(2**RK),
    RW'((2**RK + 1) / 2),   RW'((2**RK + 2) / 3),
    RW'((2**RK + 3) / 4),   RW'((2**RK + 4) / 5),
    RW'((2**RK + 5) / 6),   RW'((2**RK + 6) / 7),
    RW'((2**RK + 7) / 8),   RW'((2**RK + 8) / 9),
    RW'((2**RK + 9) / 10),  RW'((2**RK + 10) / 11),
    RW'((2**RK + 11) / 12), RW'((2**RK + 12) / 13),
    RW'((2**RK + 13) / 14), RW'((2**RK + 14) / 15)
  };

  localparam mds_lim_t HLIM [16] = '{
    LW'(SCREEN_HEIGHT),      LW'(SCREEN_HEIGHT),
    LW'(SCREEN_HEIGHT / 2),  LW'(SCREEN_HEIGHT / 3),
    LW'(SCREEN_HEIGHT / 4),  LW'(SCREEN_HEIGHT / 5),
    LW'(SCREEN_HEIGHT / 6),  LW'(SCREEN_HEIGHT / 7),
    LW'(SCREEN_HEIGHT / 8),  LW'(SCREEN_HEIGHT / 9),
    LW'(SCREEN_HEIGHT / 10), LW'(SCREEN_HEIGHT / 11),
    LW'(SCREEN_HEIGHT / 12), LW'(SCREEN_HEIGHT / 13),
    LW'(SCREEN_HEIGHT / 14), LW'(SCREEN_HEIGHT / 15)
  };

  localparam mds_lim_t WLIM [16] = '{
    LW'(SCREEN_WIDTH),      LW'(SCREEN_WIDTH),
    LW'(SCREEN_WIDTH / 2),  LW'(SCREEN_WIDTH / 3),
    LW'(SCREEN_WIDTH / 4),  LW'(SCREEN_WIDTH / 5),
    LW'(SCREEN_WIDTH / 6),  LW'(SCREEN_WIDTH / 7),
    LW'(SCREEN_WIDTH / 8),  LW'(SCREEN_WIDTH / 9),
    LW'(SCREEN_WIDTH / 10), LW'(SCREEN_WIDTH / 11),
    LW'(SCREEN_WIDTH / 12), LW'(SCREEN_WIDTH / 13),
    LW'(SCREEN_WIDTH / 14), LW'(SCREEN_WIDTH / 15)
  };

  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_SCALE      = 3'd2;
  localparam logic [2:0] REG_FLIP       = 3'd3;
  localparam logic [2:0] REG_BG_WHITE   = 3'd4;
  localparam logic [2:0] REG_ON_COLOR   = 3'd5;
  localparam logic [2:0] REG_OFF_COLOR  = 3'd6;
  localparam logic [2:0] REG_BIG_ENDIAN = 3'd7;

  typedef struct packed {
    logic [9:0]  offset_x;
    logic [9:0]  offset_y;
    logic [3:0]  scale;
    logic [1:0]  flip;
    logic        bg_white;
    logic [31:0] on_color;
    logic [31:0] off_color;
    logic        big_endian;
  } mds_cfg_t;

  // after offset and after divide
  typedef struct packed {
    logic          fetch;
    logic          wr_ok;
    logic          bg;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [7:0]    data;
  } mds_coord_t;

  // store access
  typedef struct packed {
    logic          fetch;
    logic          wr_en;
    logic          bg;
    logic          oob;
    logic [2:0]    bit_sel;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } mds_acc_t;

  typedef struct packed {
    logic       bg;
    logic       oob;
    logic [2:0] bit_sel;
  } mds_pix_t;

endpackage

@@ hw/rtl/mds_xform.sv @@
module mds_xform (
  input  logic              clk,
  input  logic              rst_n,
  input  mds_pkg::mds_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [7:0]        in_row,
  input  logic [8:0]        in_column,
  input  logic [7:0]        in_byte_data,
  output logic              acc_valid,
  output mds_pkg::mds_acc_t acc,
  input  logic              acc_rdy
);
  import mds_pkg::*;

  logic signed [SW-1:0] xm, ym, x0, y0;
  logic                 x_in, y_in;
  logic                 rdy1, rdy2, rdy3;
  logic                 v1_r, v2_r, v3_r;
  mds_coord_t           s1_nxt, s1_r, s2_nxt, s2_r;
  mds_acc_t             s3_nxt, s3_r;
  logic [PW-1:0]        px, py;
  logic                 lim_bg, oob, ok;
  logic [CW-1:0]        xoff;

  assign rdy3     = !v3_r || acc_rdy;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // mirror and shift
  always_comb begin
    xm = cfg.flip[0] ? SW'(SCREEN_WIDTH - 1) - SW'(in_column) : SW'(in_column);
    ym = cfg.flip[1] ? SW'(SCREEN_HEIGHT - 1) - SW'(in_row) : SW'(in_row);
    x0 = xm - SW'($signed(cfg.offset_x));
    y0 = ym - SW'($signed(cfg.offset_y));
    x_in = !x0[SW-1] && (x0 < $signed(SW'(SCREEN_WIDTH)));
    y_in = !y0[SW-1] && (y0 < $signed(SW'(SCREEN_HEIGHT)));
    s1_nxt.fetch = in_mode;
    s1_nxt.wr_ok = (in_row < SCREEN_HEIGHT) && (in_column < STRIDE);
    s1_nxt.bg    = !(x_in && y_in);
    s1_nxt.x     = in_mode ? x0[CW-1:0] : CW'(in_column);
    s1_nxt.y     = in_mode ? y0[CW-1:0] : CW'(in_row);
    s1_nxt.data  = in_byte_data;
  end

  // divide fetch coordinates by scale
  always_comb begin
    px = PW'(s1_r.x) * PW'(RECIP[cfg.scale]);
    py = PW'(s1_r.y) * PW'(RECIP[cfg.scale]);
    s2_nxt = s1_r;
    if (s1_r.fetch) begin
      s2_nxt.x = px[RK +: CW];
      s2_nxt.y = py[RK +: CW];
    end
  end

  // limits and address
  always_comb begin
    lim_bg = ({1'b0, s2_r.y} >= HLIM[cfg.scale]) || ({1'b0, s2_r.x} >= WLIM[cfg.scale]);
    oob    = s2_r.x >= CW'(BUFFER_WIDTH);
    xoff   = s2_r.fetch ? (s2_r.x >> 3) : s2_r.x;
    s3_nxt.fetch   = s2_r.fetch;
    s3_nxt.bg      = s2_r.bg || lim_bg;
    s3_nxt.oob     = oob;
    ok             = s2_r.fetch ? !(s3_nxt.bg || oob) : s2_r.wr_ok;
    s3_nxt.wr_en   = !s2_r.fetch && s2_r.wr_ok;
    s3_nxt.bit_sel = s2_r.x[2:0];
    s3_nxt.addr    = ok ? AW'(s2_r.y * STRIDE) + AW'(xoff) : '0;
    s3_nxt.data    = s2_r.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  assign acc_valid = v3_r;
  assign acc       = s3_r;

endmodule

@@ hw/rtl/mds_store.sv @@
module mds_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc_valid,
  input  mds_pkg::mds_acc_t acc,
  output logic              acc_rdy,
  output logic              pix_valid,
  output mds_pkg::mds_pix_t pix,
  output logic [7:0]        rd_data,
  input  logic              pix_rdy
);
  import mds_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_r;
  logic       v4_r;
  mds_pix_t   pix_r;

  assign acc_rdy = !v4_r || pix_rdy;

  always_ff @(posedge clk) begin
    if (acc_rdy) begin
      if (acc_valid && acc.wr_en) mem[acc.addr] <= acc.data;
      rd_r <= mem[acc.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_rdy) begin
      pix_r.bg      <= acc.bg;
      pix_r.oob     <= acc.oob;
      pix_r.bit_sel <= acc.bit_sel;
    end
  end

  // writes end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (acc_rdy) begin
      v4_r <= acc_valid && acc.fetch;
    end
  end

  assign pix_valid = v4_r;
  assign pix       = pix_r;
  assign rd_data   = rd_r;

endmodule

@@ hw/rtl/mono_display_scanout.sv @@
// Monochrome frame store with scan-out. Each request is either a byte write
// into the 1-bit-per-pixel store (row, byte column, eight pixels MSB leftmost)
// or a fetch of one screen pixel, which returns one 32-bit colour word; writes
// return nothing. Fetches are mirrored, offset, divided by the scale through a
// reciprocal multiply and looked up in a single-port frame memory, one access
// per request, so the block takes one request per clock while nothing stalls,
// and a fetch passes the offset, divide, address, memory and output registers.
// Results come out in request order and a write is seen by every later fetch.
// The store is not cleared at reset; read only what has been written. Change the
// configuration registers only while no request is in flight.
module mono_display_scanout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_row,
  input  logic [8:0]  in_column,
  input  logic [7:0]  in_byte_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_word
);
  import mds_pkg::*;

  mds_cfg_t    cfg_r;
  logic        acc_valid, acc_rdy;
  mds_acc_t    acc;
  logic        pix_valid, pix_rdy;
  mds_pix_t    pix;
  logic [7:0]  rd_data;
  logic        bit_on;
  logic [31:0] color, word_nxt, word_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scale: 4'd1, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X:   cfg_r.offset_x   <= cfg_wdata[9:0];
        REG_OFFSET_Y:   cfg_r.offset_y   <= cfg_wdata[9:0];
        REG_SCALE:      cfg_r.scale      <= cfg_wdata[3:0];
        REG_FLIP:       cfg_r.flip       <= cfg_wdata[1:0];
        REG_BG_WHITE:   cfg_r.bg_white   <= cfg_wdata[0];
        REG_ON_COLOR:   cfg_r.on_color   <= cfg_wdata;
        REG_OFF_COLOR:  cfg_r.off_color  <= cfg_wdata;
        REG_BIG_ENDIAN: cfg_r.big_endian <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mds_xform u_xform (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_row       (in_row),
    .in_column    (in_column),
    .in_byte_data (in_byte_data),
    .acc_valid    (acc_valid),
    .acc          (acc),
    .acc_rdy      (acc_rdy)
  );

  mds_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (acc_valid),
    .acc       (acc),
    .acc_rdy   (acc_rdy),
    .pix_valid (pix_valid),
    .pix       (pix),
    .rd_data   (rd_data),
    .pix_rdy   (pix_rdy)
  );

  assign pix_rdy = !out_valid_r || !out_stall;

  always_comb begin
    bit_on = !pix.oob && rd_data[~pix.bit_sel];
    if (pix.bg) begin
      color = cfg_r.bg_white ? cfg_r.on_color : cfg_r.off_color;
    end else begin
      color = bit_on ? cfg_r.on_color : cfg_r.off_color;
    end
    word_nxt = cfg_r.big_endian ? {color[7:0], color[15:8], color[23:16], color[31:24]}
                                : color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_rdy) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_rdy) word_r <= word_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = word_r;

endmodule

@@ hw/rtl/mds_checker.sv @@
module mds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_word))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // the pipeline only backs up from a full, stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can drain");

endmodule

bind mono_display_scanout mds_checker u_mds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_word (out_pixel_word)
);

@@ verif/mono_display_scanout_test.sv @@
`timescale 1ns / 1ps

module mono_display_scanout_test;
  import mds_pkg::*;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;
  localparam int RANDOM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 200000;

  class scanout_board;
    int offset_x = 0;
    int offset_y = 0;
    int scale = 1;
    int flip = 0;
    bit bg_white = 1'b0;
    bit big_endian = 1'b0;
    logic [31:0] on_color = '0;
    logic [31:0] off_color = '0;
    logic [7:0] store [STORE_DEPTH];
    logic [31:0] expected_words [$];
    int errors = 0;

    function new();
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_OFFSET_X:   offset_x = int'($signed(v[9:0]));
        REG_OFFSET_Y:   offset_y = int'($signed(v[9:0]));
        REG_SCALE:      scale = int'(v[3:0]);
        REG_FLIP:       flip = int'(v[1:0]);
        REG_BG_WHITE:   bg_white = v[0];
        REG_ON_COLOR:   on_color = v;
        REG_OFF_COLOR:  off_color = v;
        REG_BIG_ENDIAN: big_endian = v[0];
        default: ;
      endcase
    endfunction

    // 1 when the position lands inside the scaled screen; addr is -1 past the buffer
    function bit on_screen(logic [7:0] row, logic [8:0] col, output int addr,
                           output int bit_pos);
      int s, x, y;
      bit bg;
      s = (scale == 0) ? 1 : scale;
      y = (flip[1] ? SCREEN_HEIGHT - 1 - int'(row) : int'(row)) - offset_y;
      x = (flip[0] ? SCREEN_WIDTH - 1 - int'(col) : int'(col)) - offset_x;
      bg = 1'b0;
      if (y < 0 || y >= SCREEN_HEIGHT) begin
        bg = 1'b1;
      end else begin
        y = y / s;
        if (y >= SCREEN_HEIGHT / s) bg = 1'b1;
      end
      if (x < 0 || x >= SCREEN_WIDTH) begin
        bg = 1'b1;
      end else begin
        x = x / s;
        if (x >= SCREEN_WIDTH / s) bg = 1'b1;
      end
      addr = (x < BUFFER_WIDTH) ? y * STRIDE + x / 8 : -1;
      bit_pos = 7 - x % 8;
      return !bg;
    endfunction

    function void note_request(logic mode, logic [7:0] row, logic [8:0] col,
                               logic [7:0] data);
      int addr, bit_pos;
      logic [31:0] w;
      if (mode == MODE_WRITE) begin
        if (row < SCREEN_HEIGHT && col < STRIDE) store[int'(row) * STRIDE + int'(col)] = data;
        return;
      end
      if (!on_screen(row, col, addr, bit_pos)) w = bg_white ? on_color : off_color;
      else if (addr < 0) w = off_color;
      else w = store[addr][bit_pos] ? on_color : off_color;
      if (big_endian) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [31:0] actual);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
        $error("pixel_word expected none actual %h", actual);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (actual !== want) begin
        $error("pixel_word expected %h actual %h", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [7:0] in_row = '0;
  logic [8:0] in_column = '0;
  logic [7:0] in_byte_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_pixel_word;

  scanout_board board;
  bit written [STORE_DEPTH];
  int useful_items = 0;
  int burst_left = 0;
  int cycles = 0;
  int stall_left = 0;
  int stall_kind = 0;
  int stall_tick = 0;

  mono_display_scanout u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_byte_data   (in_byte_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_word (out_pixel_word)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_request(in_mode, in_row, in_column, in_byte_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      board.check_word(out_pixel_word);
    end
  end

  // receiver backpressure: free-running, light random, heavy random, periodic
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    stall_tick++;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_tick % 7 >= 4);
    endcase
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value, int width);
    logic [31:0] mask, wdata;
    mask = (width >= 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 32'd1;
    wdata = (value & mask) | (32'($urandom) & ~mask);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    board.set_reg(idx, wdata);
    @(negedge clk);
  endtask

  task automatic apply_settings(int ox, int oy, int sc, int fl, bit bg,
                                logic [31:0] on_c, logic [31:0] off_c, bit be);
    write_reg(REG_OFFSET_X, 32'(ox), 10);
    write_reg(REG_OFFSET_Y, 32'(oy), 10);
    write_reg(REG_SCALE, 32'(sc), 4);
    write_reg(REG_FLIP, 32'(fl), 2);
    write_reg(REG_BG_WHITE, 32'(bg), 1);
    write_reg(REG_ON_COLOR, on_c, 32);
    write_reg(REG_OFF_COLOR, off_c, 32);
    write_reg(REG_BIG_ENDIAN, 32'(be), 1);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    int ox, oy, sc;
    ox = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023)) - 512
                                     : int'($urandom_range(0, 64)) - 32;
    oy = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023)) - 512
                                     : int'($urandom_range(0, 64)) - 32;
    sc = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 15))
                                     : int'($urandom_range(1, 4));
    apply_settings(ox, oy, sc, $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                   32'($urandom), 32'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(logic mode, logic [7:0] row, logic [8:0] col, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_row <= row;
    in_column <= col;
    in_byte_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic store_byte(logic [7:0] row, logic [8:0] col, logic [7:0] data);
    if (row < SCREEN_HEIGHT && col < STRIDE) begin
      written[int'(row) * STRIDE + int'(col)] = 1'b1;
      useful_items++;
    end
    issue(MODE_WRITE, row, col, data);
  endtask

  // never read a byte that was not written first
  task automatic fetch_pixel(logic [7:0] row, logic [8:0] col);
    int addr, bit_pos;
    if (board.on_screen(row, col, addr, bit_pos) && addr >= 0 && !written[addr]) begin
      store_byte(8'(addr / STRIDE), 9'(addr % STRIDE), 8'($urandom));
    end
    useful_items++;
    issue(MODE_FETCH, row, col, 8'($urandom));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      fetch_pixel(8'($urandom_range(0, SCREEN_HEIGHT - 1)),
                  9'($urandom_range(0, SCREEN_WIDTH - 1)));
    end else if (pick < 65) begin
      fetch_pixel(8'($urandom), 9'($urandom));
    end else if (pick < 92) begin
      store_byte(8'($urandom_range(0, SCREEN_HEIGHT - 1)),
                 9'($urandom_range(0, STRIDE - 1)), 8'($urandom));
    end else begin
      store_byte(8'($urandom), 9'($urandom), 8'($urandom));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    int phase_len;
    board = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_settings(0, 0, 1, 0, 1'b0, 32'h1122_3344, 32'hA5C3_0F96, 1'b0);
    store_byte(8'd0, 9'd0, 8'h80);
    store_byte(8'd239, 9'd51, 8'h01);
    store_byte(8'd0, 9'd51, 8'hFF);
    store_byte(8'd239, 9'd0, 8'h7E);
    // out-of-range writes are dropped
    store_byte(8'd240, 9'd0, 8'hFF);
    store_byte(8'd255, 9'd511, 8'hFF);
    store_byte(8'd10, 9'd52, 8'hFF);
    fetch_pixel(8'd0, 9'd0);
    fetch_pixel(8'd0, 9'd1);
    fetch_pixel(8'd239, 9'd399);
    fetch_pixel(8'd239, 9'd0);
    fetch_pixel(8'd240, 9'd0);
    fetch_pixel(8'd0, 9'd400);
    fetch_pixel(8'd255, 9'd511);
    settle();

    // zero scale, both mirrors, positions past the screen go negative
    apply_settings(0, 0, 0, 3, 1'b1, 32'h0102_0304, 32'hF0E0_D0C0, 1'b1);
    fetch_pixel(8'd0, 9'd0);
    fetch_pixel(8'd240, 9'd0);
    fetch_pixel(8'd0, 9'd400);
    fetch_pixel(8'd255, 9'd511);
    fetch_pixel(8'd239, 9'd399);
    settle();

    apply_settings(-512, 511, 15, 1, 1'b0, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1);
    fetch_pixel(8'd0, 9'd0);
    fetch_pixel(8'd239, 9'd399);
    fetch_pixel(8'd128, 9'd256);
    settle();

    apply_settings(511, -512, 8, 2, 1'b1, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
    fetch_pixel(8'd0, 9'd0);
    fetch_pixel(8'd239, 9'd399);
    settle();

    while (useful_items < RANDOM_TARGET) begin
      random_settings();
      phase_len = $urandom_range(60, 160);
      repeat (phase_len) random_item();
      settle();
    end

    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
